FILE: rtl/core/hbe_pkg.sv
package hbe_pkg;

  // sizes of the histogram
  localparam int unsigned MAX_BINS = 256;
  localparam int unsigned DEPTH    = MAX_BINS + 2;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned IDX_W    = 9;
  localparam int unsigned ADDR_W   = $clog2(DEPTH);
  localparam int unsigned DIVD_W   = SAMPLE_W + IDX_W;
  localparam int unsigned STEP_W   = $clog2(IDX_W + 1);

  // operation carried by an input word
  typedef enum logic [1:0] {
    KIND_FILL  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_RANGE_LOW  = 2'd0,
    REG_RANGE_HIGH = 2'd1,
    REG_BIN_COUNT  = 2'd2
  } cfg_reg_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_DIV,
    ST_READ,
    ST_UPDATE,
    ST_DONE
  } state_e;

  // saturating increment of a counter
  function automatic logic [CNT_W-1:0] cnt_bump(input logic [CNT_W-1:0] v);
    cnt_bump = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
  endfunction

endpackage

FILE: rtl/core/hbe_ram.sv
module hbe_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 258
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/hbe_div.sv
module hbe_div import hbe_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [DIVD_W-1:0]   dividend_i,
  input  logic [SAMPLE_W-1:0] divisor_i,
  output logic                done_o,
  output logic [IDX_W-1:0]    quotient_o
);

  // restoring divider, one quotient bit per cycle; the quotient is known
  // to fit in IDX_W bits, so the upper dividend bits seed the remainder
  logic [SAMPLE_W-1:0] rem_q, rem_d;
  logic [IDX_W-1:0]    quo_q, quo_d;
  logic [SAMPLE_W-1:0] dvs_q, dvs_d;
  logic [STEP_W-1:0]   cnt_q, cnt_d;
  logic                done_q, done_d;
  logic [SAMPLE_W:0]   trial;
  logic                fits;

  assign trial = {rem_q, quo_q[IDX_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  // step logic
  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = dividend_i[DIVD_W-1:IDX_W];
      quo_d = dividend_i[IDX_W-1:0];
      dvs_d = divisor_i;
      cnt_d = STEP_W'(IDX_W);
    end else if (cnt_q != '0) begin
      rem_d  = fits ? SAMPLE_W'(trial - {1'b0, dvs_q}) : trial[SAMPLE_W-1:0];
      quo_d  = {quo_q[IDX_W-2:0], fits};
      cnt_d  = cnt_q - STEP_W'(1);
      done_d = (cnt_q == STEP_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  // the remainder always stays below the divisor while stepping
  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) |-> (rem_q < dvs_q))
    else $error("divider remainder not below divisor");

  // done follows the last step only
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (cnt_q == '0) && ($past(cnt_q) == STEP_W'(1)))
    else $error("divider done without last step");

  // no restart while stepping
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> (cnt_q == '0))
    else $error("divider started while busy");

endmodule

FILE: rtl/core/histogram_binning_engine.sv
// Fixed-width histogram of signed 16-bit samples with underflow/overflow bins.
// Input words arrive on the s_axis channel: tuser carries the kind (fill,
// read, clear), tdata the sample and the bin to read. Each accepted word
// gives exactly one result word on m_axis: tuser is the in-range flag,
// tdata holds bin index, bin count after the operation and the running
// in-range total. Range and bin count are set on the cfg write channel,
// which is always ready and must only be written while the block is idle.
// Work per word: an in-range fill runs the bit-serial divider (one
// quotient bit per cycle, nine bits), then the read-modify-write of the
// bin memory; a fill out of range does only the read-modify-write; a
// read reads one bin; a clear sweeps the bin memory, one entry written per
// cycle. One word is worked on at a time; tready is high only in the idle
// state, so a new word is taken at the earliest in the cycle after the
// last result is loaded. A new word may be accepted while the last
// result is still waiting; its result then waits until the output
// register is free.
// After reset the block sweeps the bin memory to zero with tready low;
// configuration writes are taken meanwhile. Counters saturate.
module histogram_binning_engine import hbe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // sample [15:0], bin_select [24:16], zero pad
  input  logic [1:0]  s_axis_tuser,  // kind [1:0]
  // result words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,  // bin_index [8:0], bin_value [40:9],
                                     // total_in_range [72:41], zero pad
  output logic        m_axis_tuser   // in_range
);

  state_e state_q, state_d;

  // configuration registers
  logic signed [SAMPLE_W-1:0] lo_q, hi_q;
  logic [IDX_W-1:0]           bcnt_q;
  logic [IDX_W-1:0]           n_eff;

  // working registers
  kind_e                      kind_q, kind_d;
  logic signed [SAMPLE_W-1:0] x_q, x_d;
  logic [IDX_W-1:0]           idx_q, idx_d;
  logic                       flag_q, flag_d;
  logic [CNT_W-1:0]           val_q, val_d;
  logic [CNT_W-1:0]           total_q, total_d;
  logic [ADDR_W-1:0]          caddr_q, caddr_d;
  logic                       clr_item_q, clr_item_d;

  // output register
  logic                       mvalid_q, mvalid_d;
  logic                       mflag_q, mflag_d;
  logic [IDX_W-1:0]           midx_q, midx_d;
  logic [CNT_W-1:0]           mval_q, mval_d;
  logic [CNT_W-1:0]           mtot_q, mtot_d;

  // memory and divider hookup
  logic                       ram_we, ram_re;
  logic [ADDR_W-1:0]          ram_waddr;
  logic [CNT_W-1:0]           ram_wdata, ram_rdata;
  logic                       div_start, div_done;
  logic [IDX_W-1:0]           div_quo;

  // input unpacking
  logic signed [SAMPLE_W-1:0] in_sample;
  logic [IDX_W-1:0]           in_sel;
  logic [IDX_W-1:0]           sel_clamped;
  logic                       accept;
  logic                       out_free;

  // in-range arithmetic
  logic signed [SAMPLE_W:0]   off_w, span_w;
  logic [DIVD_W-1:0]          prod_w;
  logic                       below, above;
  logic [IDX_W-1:0]           quo_clamped;

  assign in_sample = s_axis_tdata[SAMPLE_W-1:0];
  assign in_sel    = s_axis_tdata[SAMPLE_W+IDX_W-1:SAMPLE_W];
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign out_free  = !mvalid_q || m_axis_tready;

  // effective bin count, forced into 1..MAX_BINS
  always_comb begin
    if (bcnt_q == '0) begin
      n_eff = IDX_W'(1);
    end else if (bcnt_q > IDX_W'(MAX_BINS)) begin
      n_eff = IDX_W'(MAX_BINS);
    end else begin
      n_eff = bcnt_q;
    end
  end

  // read select beyond overflow reads the overflow bin
  assign sel_clamped = (in_sel > n_eff + IDX_W'(1)) ? n_eff + IDX_W'(1) : in_sel;

  // offset and span of the sample window
  assign off_w  = {x_q[SAMPLE_W-1], x_q} - {lo_q[SAMPLE_W-1], lo_q};
  assign span_w = {hi_q[SAMPLE_W-1], hi_q} - {lo_q[SAMPLE_W-1], lo_q};
  assign below  = x_q < lo_q;
  assign above  = x_q >= hi_q;

  // scaled offset, taken by the divider when it starts
  assign prod_w = DIVD_W'(off_w[SAMPLE_W-1:0]) * DIVD_W'(n_eff);

  assign quo_clamped = (div_quo >= n_eff) ? n_eff - IDX_W'(1) : div_quo;

  // configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q   <= '0;
      hi_q   <= 16'sh7fff;
      bcnt_q <= IDX_W'(MAX_BINS);
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_RANGE_LOW:  lo_q   <= cfg_data_i;
        REG_RANGE_HIGH: hi_q   <= cfg_data_i;
        REG_BIN_COUNT:  bcnt_q <= cfg_data_i[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (caddr_q == ADDR_W'(DEPTH - 1)) begin
          state_d = clr_item_q ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (kind_e'(s_axis_tuser))
            KIND_FILL:  state_d = ST_CALC;
            KIND_READ:  state_d = ST_READ;
            KIND_CLEAR: state_d = ST_CLEAR;
            default:    state_d = ST_DONE;
          endcase
        end
      end
      ST_CALC:   state_d = (below || above) ? ST_READ : ST_DIV;
      ST_DIV:    state_d = div_done ? ST_READ : ST_DIV;
      ST_READ:   state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_DONE;
      ST_DONE:   state_d = out_free ? ST_IDLE : ST_DONE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // control outputs of the sequencer
  always_comb begin
    s_axis_tready = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = idx_q[ADDR_W-1:0];
    ram_wdata     = '0;
    div_start     = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = caddr_q;
      end
      ST_IDLE:  s_axis_tready = 1'b1;
      ST_CALC:  div_start = !(below || above);
      ST_READ:  ram_re = 1'b1;
      ST_UPDATE: begin
        ram_we    = (kind_q == KIND_FILL);
        ram_wdata = cnt_bump(ram_rdata);
      end
      default: ;
    endcase
  end

  // datapath registers
  always_comb begin
    kind_d     = kind_q;
    x_d        = x_q;
    idx_d      = idx_q;
    flag_d     = flag_q;
    val_d      = val_q;
    total_d    = total_q;
    caddr_d    = caddr_q;
    clr_item_d = clr_item_q;
    mvalid_d   = mvalid_q && !m_axis_tready;
    mflag_d    = mflag_q;
    midx_d     = midx_q;
    mval_d     = mval_q;
    mtot_d     = mtot_q;
    unique case (state_q)
      ST_CLEAR: begin
        caddr_d = caddr_q + ADDR_W'(1);
        total_d = '0;
      end
      ST_IDLE: begin
        if (accept) begin
          kind_d     = kind_e'(s_axis_tuser);
          x_d        = in_sample;
          idx_d      = '0;
          flag_d     = 1'b0;
          val_d      = '0;
          caddr_d    = '0;
          clr_item_d = 1'b1;
          if (kind_e'(s_axis_tuser) == KIND_READ) begin
            idx_d  = sel_clamped;
            flag_d = (sel_clamped != '0) && (sel_clamped <= n_eff);
          end
        end
      end
      ST_CALC: begin
        if (below) begin
          idx_d = '0;
        end else if (above) begin
          idx_d = n_eff + IDX_W'(1);
        end else begin
          flag_d = 1'b1;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          idx_d = quo_clamped + IDX_W'(1);
        end
      end
      ST_UPDATE: begin
        if (kind_q == KIND_FILL) begin
          val_d = cnt_bump(ram_rdata);
          if (flag_q) begin
            total_d = cnt_bump(total_q);
          end
        end else begin
          val_d = ram_rdata;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          mvalid_d = 1'b1;
          mflag_d  = flag_q;
          midx_d   = idx_q;
          mval_d   = val_q;
          mtot_d   = total_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      caddr_q    <= '0;
      clr_item_q <= 1'b0;
      total_q    <= '0;
      mvalid_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      caddr_q    <= caddr_d;
      clr_item_q <= clr_item_d;
      total_q    <= total_d;
      mvalid_q   <= mvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    x_q    <= x_d;
    idx_q  <= idx_d;
    flag_q <= flag_d;
    val_q  <= val_d;
    mflag_q <= mflag_d;
    midx_q <= midx_d;
    mval_q <= mval_d;
    mtot_q <= mtot_d;
  end

  // bin counter store
  hbe_ram #(
    .WIDTH (CNT_W),
    .DEPTH (DEPTH)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q[ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // serial bin index divider
  hbe_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_w),
    .divisor_i  (span_w[SAMPLE_W-1:0]),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // result packing
  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tuser  = mflag_q;
  assign m_axis_tdata  = {7'd0, mtot_q, mval_q, midx_q};

  // an in-range result always names a bin inside 1..n
  a_flag_bin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && flag_q) |-> (idx_q != '0) && (idx_q <= n_eff))
    else $error("in-range result outside the in-range bins");

  // quotient never reaches the bin count since offset is below span
  a_quo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && div_done) |-> (div_quo < n_eff))
    else $error("bin quotient out of range");

  // the in-range total only drops by a clear sweep
  a_total_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (total_q >= $past(total_q)) || ($past(state_q) == ST_CLEAR))
    else $error("in-range total dropped outside a clear");

  // memory is written only by the sweep or by a fill update
  a_write_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_CLEAR) ||
               (state_q == ST_UPDATE && kind_q == KIND_FILL))
    else $error("unexpected bin memory write");

endmodule

FILE: sim/histogram_binning_engine_test.sv
`timescale 1ns / 1ps

module histogram_binning_engine_test import hbe_pkg::*;;

  // operation code with no defined meaning
  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int unsigned IDLE_GUARD = 20;
  localparam int unsigned RAND_PER_HALF = 80;
  localparam int unsigned HOLD_OFF_CYCLES = 400;

  typedef struct packed {
    logic        in_range;
    logic [8:0]  bin_index;
    logic [31:0] bin_value;
    logic [31:0] total;
  } bin_reply_t;

  // one row of the directed plan: a register write or an input word
  typedef struct {
    bit          is_write;
    cfg_reg_e    reg_idx;
    logic [1:0]  kind;
    logic [15:0] value;
    logic [8:0]  sel;
    bit          has_want;
    bin_reply_t  want;
  } plan_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic        m_axis_tuser;

  histogram_binning_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // shadow copy of the histogram and its settings
  logic [31:0] shadow_bins [0:DEPTH-1];
  logic [31:0] shadow_total;
  logic [15:0] cur_low;
  logic [15:0] cur_high;
  logic [8:0]  cur_count;

  bin_reply_t  pending_replies [$];
  plan_row_t   plan [$];

  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned hold_cycles = 0;
  int unsigned n_items = 0;
  int unsigned n_checked = 0;
  int unsigned n_writes = 0;
  int unsigned n_errors = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // number of bins in use after clamping to 1..MAX_BINS
  function automatic longint eff_bins();
    longint n;
    n = cur_count;
    if (n == 0) n = 1;
    if (n > MAX_BINS) n = MAX_BINS;
    return n;
  endfunction

  // applies one input word to the shadow histogram, returns the result word
  function automatic bin_reply_t histo_apply(input logic [1:0] k, input logic [15:0] smp,
                                             input logic [8:0] sel);
    bin_reply_t r;
    longint n, x, lo, hi, b, idx;
    r = '0;
    n = eff_bins();
    case (k)
      KIND_FILL: begin
        x = $signed(smp);
        lo = $signed(cur_low);
        hi = $signed(cur_high);
        if (x < lo) begin
          idx = 0;
        end else if (x >= hi) begin
          idx = n + 1;
        end else begin
          b = ((x - lo) * n) / (hi - lo);
          if (b >= n) b = n - 1;
          idx = b + 1;
          r.in_range = 1'b1;
          shadow_total = sat_inc(shadow_total);
        end
        shadow_bins[idx] = sat_inc(shadow_bins[idx]);
        r.bin_index = 9'(idx);
        r.bin_value = shadow_bins[idx];
      end
      KIND_READ: begin
        idx = sel;
        if (idx > n + 1) idx = n + 1;
        r.in_range = (idx >= 1 && idx <= n);
        r.bin_index = 9'(idx);
        r.bin_value = shadow_bins[idx];
      end
      KIND_CLEAR: begin
        for (int i = 0; i < DEPTH; i++) shadow_bins[i] = '0;
        shadow_total = '0;
      end
      default: ;
    endcase
    r.total = shadow_total;
    return r;
  endfunction

  function automatic plan_row_t op(input logic [1:0] k, input logic [15:0] v,
                                   input logic [8:0] s);
    plan_row_t row;
    row.is_write = 1'b0;
    row.reg_idx = REG_RANGE_LOW;
    row.kind = k;
    row.value = v;
    row.sel = s;
    row.has_want = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic plan_row_t known(input plan_row_t row, input logic f,
                                      input int unsigned idx, input int unsigned val,
                                      input int unsigned tot);
    plan_row_t r;
    r = row;
    r.has_want = 1'b1;
    r.want.in_range = f;
    r.want.bin_index = 9'(idx);
    r.want.bin_value = val;
    r.want.total = tot;
    return r;
  endfunction

  function automatic plan_row_t reg_wr(input cfg_reg_e ri, input logic [15:0] d);
    plan_row_t r;
    r = op(KIND_FILL, d, '0);
    r.is_write = 1'b1;
    r.reg_idx = ri;
    return r;
  endfunction

  task automatic note_mismatch(input string what, input longint unsigned got,
                               input longint unsigned want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    n_errors++;
  endtask

  // offers one word, keeps tvalid high so a following word can go back to back
  task automatic push_word(input logic [1:0] k, input logic [15:0] smp, input logic [8:0] sel,
                           input bit has_want, input bin_reply_t want);
    bin_reply_t guess;
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < src_idle_pct) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= k;
    s_axis_tdata <= {7'd0, sel, smp};
    do @(posedge clk_i); while (!s_axis_tready);
    guess = histo_apply(k, smp, sel);
    pending_replies.push_back(has_want ? want : guess);
    n_items++;
  endtask

  task automatic write_reg(input cfg_reg_e ri, input logic [15:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= ri;
    cfg_data_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (ri)
      REG_RANGE_LOW:  cur_low = d;
      REG_RANGE_HIGH: cur_high = d;
      default:        cur_count = d[8:0];
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    n_writes++;
  endtask

  // stop offering and wait for every outstanding result
  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (IDLE_GUARD) @(posedge clk_i);
  endtask

  // random range and bin count, extremes and inverted ranges among them
  task automatic pick_settings();
    logic [15:0] a, b;
    logic [8:0]  cnt;
    a = 16'($urandom_range(16'hFFFF));
    b = 16'($urandom_range(16'hFFFF));
    case ($urandom_range(9))
      0: begin
        a = 16'h8000;
        b = 16'h7FFF;
      end
      1: ;
      2: b = ($signed(a) > 16'sh7FC0) ? 16'h7FFF : a + 16'($urandom_range(1, 63));
      default: if ($signed(a) > $signed(b)) {a, b} = {b, a};
    endcase
    case ($urandom_range(9))
      0: cnt = 9'd0;
      1: cnt = 9'd1;
      2: cnt = 9'd256;
      3: cnt = 9'($urandom_range(257, 511));
      default: cnt = 9'($urandom_range(1, 256));
    endcase
    write_reg(REG_RANGE_LOW, a);
    write_reg(REG_RANGE_HIGH, b);
    write_reg(REG_BIN_COUNT, {7'($urandom_range(127)), cnt});
  endtask

  // mostly fills inside the range, some edge samples, reads of live bins
  task automatic send_random();
    logic [1:0]  k;
    logic [15:0] smp;
    logic [8:0]  sel;
    int unsigned roll;
    longint lo, hi, n;
    lo = $signed(cur_low);
    hi = $signed(cur_high);
    n = eff_bins();
    roll = $urandom_range(99);
    if (roll < 62) k = KIND_FILL;
    else if (roll < 90) k = KIND_READ;
    else if (roll < 93) k = KIND_CLEAR;
    else k = KIND_SPARE;
    smp = 16'($urandom_range(16'hFFFF));
    sel = 9'($urandom_range(9'h1FF));
    roll = $urandom_range(99);
    if (k == KIND_FILL && hi > lo) begin
      if (roll < 70) begin
        smp = 16'(lo + longint'($urandom_range(32'(hi - lo - 1))));
      end else if (roll < 85) begin
        case ($urandom_range(3))
          0: smp = 16'(lo - 1);
          1: smp = 16'(lo);
          2: smp = 16'(hi - 1);
          default: smp = 16'(hi);
        endcase
      end
    end else if (k == KIND_READ && roll < 80) begin
      sel = 9'($urandom_range(32'(n + 1)));
    end
    push_word(k, smp, sel, 1'b0, '0);
  endtask

  // result side: check each word, then decide tready for the next cycle
  initial begin
    bin_reply_t want;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_replies.size() == 0) begin
          note_mismatch("result word with nothing pending, bin_index", m_axis_tdata[8:0], 0);
        end else begin
          want = pending_replies.pop_front();
          if (m_axis_tuser !== want.in_range)
            note_mismatch("in_range", m_axis_tuser, want.in_range);
          if (m_axis_tdata[8:0] !== want.bin_index)
            note_mismatch("bin_index", m_axis_tdata[8:0], want.bin_index);
          if (m_axis_tdata[40:9] !== want.bin_value)
            note_mismatch("bin_value", m_axis_tdata[40:9], want.bin_value);
          if (m_axis_tdata[72:41] !== want.total)
            note_mismatch("total_in_range", m_axis_tdata[72:41], want.total);
          n_checked++;
        end
      end
      if (hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        hold_cycles--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  initial begin
    for (int i = 0; i < DEPTH; i++) shadow_bins[i] = '0;
    shadow_total = '0;
    cur_low = 16'h0000;
    cur_high = 16'h7FFF;
    cur_count = 9'd256;

    // directed plan: reset state, extremes, every kind and the corner cases
    plan.push_back(known(op(KIND_READ, 16'h0000, 9'd0), 1'b0, 0, 0, 0));
    plan.push_back(known(op(KIND_READ, 16'hFFFF, 9'd300), 1'b0, 257, 0, 0));
    plan.push_back(known(op(KIND_FILL, 16'h0000, 9'd0), 1'b1, 1, 1, 1));
    plan.push_back(known(op(KIND_FILL, 16'h8000, 9'h1FF), 1'b0, 0, 1, 1));
    plan.push_back(known(op(KIND_FILL, 16'h7FFF, 9'd0), 1'b0, 257, 1, 1));
    plan.push_back(op(KIND_FILL, 16'h7FFE, 9'h1FF));
    plan.push_back(known(op(KIND_SPARE, 16'hFFFF, 9'h1FF), 1'b0, 0, 0, 2));
    plan.push_back(op(KIND_READ, 16'h0000, 9'd256));
    plan.push_back(known(op(KIND_READ, 16'h0000, 9'd257), 1'b0, 257, 1, 2));
    plan.push_back(known(op(KIND_CLEAR, 16'hFFFF, 9'h1FF), 1'b0, 0, 0, 0));
    plan.push_back(known(op(KIND_READ, 16'h0000, 9'd1), 1'b1, 1, 0, 0));
    // zero bins acts as one
    plan.push_back(reg_wr(REG_BIN_COUNT, 16'd0));
    plan.push_back(op(KIND_FILL, 16'd100, 9'd0));
    plan.push_back(op(KIND_READ, 16'h0000, 9'd2));
    plan.push_back(op(KIND_READ, 16'h0000, 9'h1FF));
    // widest range
    plan.push_back(reg_wr(REG_RANGE_LOW, 16'h8000));
    plan.push_back(reg_wr(REG_RANGE_HIGH, 16'h7FFF));
    plan.push_back(reg_wr(REG_BIN_COUNT, 16'd256));
    plan.push_back(op(KIND_FILL, 16'h8000, 9'd0));
    plan.push_back(op(KIND_FILL, 16'h7FFE, 9'd0));
    plan.push_back(op(KIND_FILL, 16'h7FFF, 9'd0));
    // bin count above the maximum, upper data bits set
    plan.push_back(reg_wr(REG_BIN_COUNT, 16'hFFFF));
    plan.push_back(op(KIND_FILL, 16'h0000, 9'd0));
    // empty range, then inverted extremes
    plan.push_back(reg_wr(REG_RANGE_LOW, 16'd100));
    plan.push_back(reg_wr(REG_RANGE_HIGH, 16'd100));
    plan.push_back(op(KIND_FILL, 16'd99, 9'd0));
    plan.push_back(op(KIND_FILL, 16'd100, 9'd0));
    plan.push_back(reg_wr(REG_RANGE_LOW, 16'h7FFF));
    plan.push_back(reg_wr(REG_RANGE_HIGH, 16'h8000));
    plan.push_back(op(KIND_FILL, 16'h7FFF, 9'd0));
    plan.push_back(op(KIND_FILL, 16'h8000, 9'd0));
    // single bin of width one
    plan.push_back(reg_wr(REG_RANGE_LOW, 16'd0));
    plan.push_back(reg_wr(REG_RANGE_HIGH, 16'd1));
    plan.push_back(reg_wr(REG_BIN_COUNT, 16'd1));
    plan.push_back(op(KIND_FILL, 16'h0000, 9'd0));
    plan.push_back(op(KIND_READ, 16'h0000, 9'd3));
    plan.push_back(op(KIND_CLEAR, 16'h0000, 9'd0));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    src_idle_pct = 22;
    sink_stall_pct = 22;
    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        settle_block();
        write_reg(plan[i].reg_idx, plan[i].value);
      end else begin
        push_word(plan[i].kind, plan[i].value, plan[i].sel, plan[i].has_want, plan[i].want);
      end
    end

    // random part in four pacing phases, settings changed mid-phase too
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 82; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 82; end
        default: begin src_idle_pct = 22; sink_stall_pct = 22; end
      endcase
      for (int half = 0; half < 2; half++) begin
        settle_block();
        pick_settings();
        // long output hold-off while words keep coming
        if (ph == 0 && half == 0) hold_cycles = HOLD_OFF_CYCLES;
        repeat (RAND_PER_HALF) send_random();
      end
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (2 * IDLE_GUARD) @(posedge clk_i);

    $display("tb: %0d input words sent, %0d result words compared, %0d register writes",
             n_items, n_checked, n_writes);
    $display("tb: directed corners plus four pacing phases and one long hold-off, %0d mismatches",
             n_errors);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
